@@ design/rtcsam_pkg.sv @@
// ----------------------------------------------------------------------------
// rtcsam_pkg
// Shared types and constants for the RTC serial access master: field widths,
// register indexes and reset values, status codes, sequencer phases and the
// structs passed between the top level and the sequencer.
// ----------------------------------------------------------------------------
package rtcsam_pkg;

   // Field widths
   localparam int ADDR_W     = 8;
   localparam int DATA_W     = 32;
   localparam int HALF_W     = 16;
   localparam int WAIT_W     = 20;
   localparam int POLL_W     = 16;
   localparam int RETRY_W    = 4;
   localparam int TICK_W     = 20;
   localparam int TRY_W      = 5;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // Default frame lengths
   localparam int DEF_ADDR_BITS = 8;
   localparam int DEF_DATA_BITS = 32;

   // Register reset values
   localparam logic [HALF_W-1:0]  HALF_PERIOD_RST = 16'd100;
   localparam logic [WAIT_W-1:0]  OSC_WAIT_RST    = 20'd5000;
   localparam logic [WAIT_W-1:0]  RETRY_GAP_RST   = 20'd10000;
   localparam logic [POLL_W-1:0]  POLL_LIMIT_RST  = 16'd40000;
   localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_PERIOD = 3'd0,
      CSR_OSC_WAIT    = 3'd1,
      CSR_RETRY_GAP   = 3'd2,
      CSR_POLL_LIMIT  = 3'd3,
      CSR_RETRY_LIMIT = 3'd4
   } csr_index_type;

   // Completion status
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OSC_STOP = 2'd1,
      STATUS_TIMEOUT  = 2'd2
   } status_type;

   // Sequencer phases, one-hot
   typedef enum logic [9:0] {
      PH_IDLE  = 10'b00_0000_0001,
      PH_OSC   = 10'b00_0000_0010,
      PH_POLL  = 10'b00_0000_0100,
      PH_GAP   = 10'b00_0000_1000,
      PH_SDATA = 10'b00_0001_0000,
      PH_SADDR = 10'b00_0010_0000,
      PH_MODE  = 10'b00_0100_0000,
      PH_GET   = 10'b00_1000_0000,
      PH_FPOLL = 10'b01_0000_0000,
      PH_FGAP  = 10'b10_0000_0000
   } phase_type;

   // Configuration registers
   typedef struct packed {
      logic [HALF_W-1:0]  half_period;
      logic [WAIT_W-1:0]  osc_wait;
      logic [WAIT_W-1:0]  retry_gap;
      logic [POLL_W-1:0]  poll_limit;
      logic [RETRY_W-1:0] retry_limit;
   } cfg_type;

   // One tick of input
   typedef struct packed {
      logic              start_req;
      logic              opcode;
      logic [ADDR_W-1:0] reg_addr;
      logic [DATA_W-1:0] write_value;
      logic              ready_in;
      logic              sdo_in;
      logic [DATA_W-1:0] osc_count;
   } req_item_type;

   // One tick of output
   typedef struct packed {
      logic                sclk;
      logic                sdi;
      logic                sen;
      logic                sbus;
      logic                count_enable;
      logic                busy_res;
      logic                done_res;
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   read_value;
   } rsp_item_type;

endpackage

@@ design/rtcsam_if.sv @@
// ----------------------------------------------------------------------------
// rtcsam_req_if / rtcsam_rsp_if
// Valid/ready channels of the RTC serial access master: one tick of inputs in,
// one tick of line levels and completion status out.
// ----------------------------------------------------------------------------
interface rtcsam_req_if;
   import rtcsam_pkg::*;

   logic              valid;
   logic              ready;
   logic              start_req;
   logic              opcode;
   logic [ADDR_W-1:0] reg_addr;
   logic [DATA_W-1:0] write_value;
   logic              ready_in;
   logic              sdo_in;
   logic [DATA_W-1:0] osc_count;

   modport source (
      output valid, start_req, opcode, reg_addr, write_value, ready_in, sdo_in,
             osc_count,
      input  ready
   );
   modport sink (
      input  valid, start_req, opcode, reg_addr, write_value, ready_in, sdo_in,
             osc_count,
      output ready
   );
endinterface

interface rtcsam_rsp_if;
   import rtcsam_pkg::*;

   logic                valid;
   logic                ready;
   logic                sclk;
   logic                sdi;
   logic                sen;
   logic                sbus;
   logic                count_enable;
   logic                busy_res;
   logic                done_res;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   read_value;

   modport source (
      output valid, sclk, sdi, sen, sbus, count_enable, busy_res, done_res,
             status, read_value,
      input  ready
   );
   modport sink (
      input  valid, sclk, sdi, sen, sbus, count_enable, busy_res, done_res,
             status, read_value,
      output ready
   );
endinterface

@@ design/rtcsam_seq.sv @@
// ----------------------------------------------------------------------------
// rtcsam_seq
// Access sequencer: oscillator check on reads, ready polling with retries, serial
// shift out of data/address/mode and shift in of read data. Advances one
// tick per step and returns the line levels after that tick.
// ----------------------------------------------------------------------------
module rtcsam_seq #(
   parameter int ADDR_BITS = rtcsam_pkg::DEF_ADDR_BITS,
   parameter int DATA_BITS = rtcsam_pkg::DEF_DATA_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  rtcsam_pkg::req_item_type item,
   input  rtcsam_pkg::cfg_type      cfg,
   output rtcsam_pkg::rsp_item_type result
);
   import rtcsam_pkg::*;

   localparam int MAX_BITS = (DATA_BITS > ADDR_BITS) ? DATA_BITS : ADDR_BITS;
   localparam int CNT_W    = $clog2(MAX_BITS + 1);

   // State
   phase_type             phase_ff, phase_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [POLL_W-1:0]     poll_ff, poll_in;
   logic [TRY_W-1:0]      inner_ff, inner_in;
   logic [TRY_W-1:0]      outer_ff, outer_in;
   logic [CNT_W-1:0]      bit_ff, bit_in;
   logic [DATA_BITS-1:0]  shift_ff, shift_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic                  write_ff, write_in;
   logic [DATA_W-1:0]     osc_ff, osc_in;

   // Datapath helpers
   logic [HALF_W-1:0]     half_eff;
   logic [HALF_W:0]       two_half;
   logic [TICK_W:0]       tick_inc;
   logic                  pulse_done;
   logic [POLL_W-1:0]     poll_dec;
   logic [TRY_W-1:0]      limit_ext;
   logic                  done;
   status_type            status;
   logic [DATA_W-1:0]     value;
   logic                  pulse_phase;

   assign half_eff   = (cfg.half_period == '0) ? HALF_W'(1) : cfg.half_period;
   assign two_half   = {half_eff, 1'b0};
   assign tick_inc   = {1'b0, tick_ff} + (TICK_W+1)'(1);
   assign pulse_done = tick_inc >= (TICK_W+1)'(two_half);
   assign poll_dec   = poll_ff - POLL_W'(1);
   assign limit_ext  = TRY_W'(cfg.retry_limit);

   // Next state for one tick
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      poll_in  = poll_ff;
      inner_in = inner_ff;
      outer_in = outer_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      addr_in  = addr_ff;
      write_in = write_ff;
      osc_in   = osc_ff;
      done     = 1'b0;
      status   = STATUS_OK;
      value    = '0;

      case (phase_ff)
         PH_IDLE: begin
            if (item.start_req) begin
               write_in = item.opcode;
               addr_in  = item.reg_addr[ADDR_BITS-1:0];
               shift_in = item.opcode ? item.write_value[DATA_BITS-1:0] : '0;
               outer_in = '0;
               bit_in   = '0;
               tick_in  = '0;
               if (item.opcode) begin
                  phase_in = PH_POLL;
                  poll_in  = cfg.poll_limit;
                  inner_in = '0;
               end else begin
                  osc_in   = item.osc_count;
                  phase_in = PH_OSC;
               end
            end
         end
         PH_OSC: begin
            tick_in = tick_inc[TICK_W-1:0];
            if (tick_inc >= (TICK_W+1)'(cfg.osc_wait)) begin
               if (item.osc_count == osc_ff) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
                  status   = STATUS_OSC_STOP;
               end else begin
                  phase_in = PH_POLL;
                  poll_in  = cfg.poll_limit;
                  inner_in = '0;
                  tick_in  = '0;
               end
            end
         end
         PH_POLL, PH_FPOLL: begin
            if (item.ready_in) begin
               if (phase_ff == PH_FPOLL) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  phase_in = write_ff ? PH_SDATA : PH_SADDR;
                  bit_in   = '0;
                  tick_in  = '0;
               end
            end else begin
               poll_in = poll_dec;
               if (poll_dec == '0) begin
                  tick_in = '0;
                  if (inner_ff > limit_ext) begin
                     if (phase_ff == PH_FPOLL) begin
                        // final wait outcome is not checked
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end else if (outer_ff > limit_ext) begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                        status   = STATUS_TIMEOUT;
                     end else begin
                        outer_in = outer_ff + TRY_W'(1);
                        inner_in = '0;
                        phase_in = PH_GAP;
                     end
                  end else begin
                     inner_in = inner_ff + TRY_W'(1);
                     phase_in = (phase_ff == PH_FPOLL) ? PH_FGAP : PH_GAP;
                  end
               end
            end
         end
         PH_GAP, PH_FGAP: begin
            tick_in = tick_inc[TICK_W-1:0];
            if (tick_inc >= (TICK_W+1)'(cfg.retry_gap)) begin
               tick_in  = '0;
               poll_in  = cfg.poll_limit;
               phase_in = (phase_ff == PH_FGAP) ? PH_FPOLL : PH_POLL;
            end
         end
         PH_SDATA: begin
            tick_in = tick_inc[TICK_W-1:0];
            if (pulse_done) begin
               tick_in  = '0;
               shift_in = shift_ff << 1;
               bit_in   = bit_ff + CNT_W'(1);
               if (bit_ff == CNT_W'(DATA_BITS - 1)) begin
                  bit_in   = '0;
                  phase_in = PH_SADDR;
               end
            end
         end
         PH_SADDR: begin
            tick_in = tick_inc[TICK_W-1:0];
            if (pulse_done) begin
               tick_in = '0;
               addr_in = addr_ff << 1;
               bit_in  = bit_ff + CNT_W'(1);
               if (bit_ff == CNT_W'(ADDR_BITS - 1)) begin
                  bit_in   = '0;
                  phase_in = PH_MODE;
               end
            end
         end
         PH_MODE: begin
            tick_in = tick_inc[TICK_W-1:0];
            if (pulse_done) begin
               tick_in = '0;
               bit_in  = '0;
               if (write_ff) begin
                  phase_in = PH_FPOLL;
                  poll_in  = cfg.poll_limit;
                  inner_in = '0;
               end else begin
                  shift_in = '0;
                  phase_in = PH_GET;
               end
            end
         end
         PH_GET: begin
            tick_in = tick_inc[TICK_W-1:0];
            if (pulse_done) begin
               tick_in  = '0;
               shift_in = (shift_ff << 1) | DATA_BITS'(item.sdo_in);
               bit_in   = bit_ff + CNT_W'(1);
               if (bit_ff == CNT_W'(DATA_BITS - 1)) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
                  value    = DATA_W'(shift_in);
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Line levels after this tick
   assign pulse_phase = (phase_in == PH_SDATA) || (phase_in == PH_SADDR) ||
                        (phase_in == PH_MODE)  || (phase_in == PH_GET);

   always_comb begin
      result              = '0;
      result.sbus         = (phase_in == PH_IDLE) || (phase_in == PH_OSC);
      result.count_enable = (phase_in == PH_OSC);
      result.sclk         = pulse_phase && (tick_in >= TICK_W'(half_eff));
      result.sen          = (phase_in == PH_SDATA) || (phase_in == PH_SADDR);
      case (phase_in)
         PH_SDATA: result.sdi = shift_in[DATA_BITS-1];
         PH_SADDR: result.sdi = addr_in[ADDR_BITS-1];
         PH_MODE:  result.sdi = write_ff;
         default:  result.sdi = 1'b0;
      endcase
      result.busy_res   = (phase_in != PH_IDLE);
      result.done_res   = done;
      result.status     = status;
      result.read_value = value;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         poll_ff  <= '0;
         inner_ff <= '0;
         outer_ff <= '0;
         bit_ff   <= '0;
         write_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         poll_ff  <= poll_in;
         inner_ff <= inner_in;
         outer_ff <= outer_in;
         bit_ff   <= bit_in;
         write_ff <= write_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (step) begin
         shift_ff <= shift_in;
         addr_ff  <= addr_in;
         osc_ff   <= osc_in;
      end
   end

endmodule

@@ design/rtc_serial_access_master_top.sv @@
// Result: the result for a tick is registered and presented in the cycle after it is accepted.
// Throughput: one tick per cycle unless the output stalls; the sequencer state updates in a single pass
// and the result register lets a new tick in while the last result is taken.
// Reset (synchronous): sequencer returns to idle, output register empties and
// the configuration registers return to their default values.
// ----------------------------------------------------------------------------
// rtc_serial_access_master_top
// Bit-banged RTC serial master: configuration registers, input handshake,
// sequencer and output register.
// ----------------------------------------------------------------------------
module rtc_serial_access_master_top #(
   parameter int ADDR_BITS = rtcsam_pkg::DEF_ADDR_BITS,
   parameter int DATA_BITS = rtcsam_pkg::DEF_DATA_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   rtcsam_req_if.sink                        req_ch,
   rtcsam_rsp_if.source                      rsp_ch,
   input  logic                              csr_we,
   input  logic [rtcsam_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rtcsam_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rtcsam_pkg::*;

   cfg_type      cfg_ff;
   req_item_type item;
   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;
   logic         req_fire;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period <= HALF_PERIOD_RST;
         cfg_ff.osc_wait    <= OSC_WAIT_RST;
         cfg_ff.retry_gap   <= RETRY_GAP_RST;
         cfg_ff.poll_limit  <= POLL_LIMIT_RST;
         cfg_ff.retry_limit <= RETRY_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HALF_PERIOD: cfg_ff.half_period <= csr_wdata[HALF_W-1:0];
            CSR_OSC_WAIT:    cfg_ff.osc_wait    <= csr_wdata[WAIT_W-1:0];
            CSR_RETRY_GAP:   cfg_ff.retry_gap   <= csr_wdata[WAIT_W-1:0];
            CSR_POLL_LIMIT:  cfg_ff.poll_limit  <= csr_wdata[POLL_W-1:0];
            CSR_RETRY_LIMIT: cfg_ff.retry_limit <= csr_wdata[RETRY_W-1:0];
            default: ;
         endcase
      end
   end

   // Input handshake
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign item.start_req   = req_ch.start_req;
   assign item.opcode      = req_ch.opcode;
   assign item.reg_addr    = req_ch.reg_addr;
   assign item.write_value = req_ch.write_value;
   assign item.ready_in    = req_ch.ready_in;
   assign item.sdo_in      = req_ch.sdo_in;
   assign item.osc_count   = req_ch.osc_count;

   rtcsam_seq #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (req_fire),
      .item   (item),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.sclk         = rsp_ff.sclk;
   assign rsp_ch.sdi          = rsp_ff.sdi;
   assign rsp_ch.sen          = rsp_ff.sen;
   assign rsp_ch.sbus         = rsp_ff.sbus;
   assign rsp_ch.count_enable = rsp_ff.count_enable;
   assign rsp_ch.busy_res     = rsp_ff.busy_res;
   assign rsp_ch.done_res     = rsp_ff.done_res;
   assign rsp_ch.status       = rsp_ff.status;
   assign rsp_ch.read_value   = rsp_ff.read_value;

   // Checks
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   a_error_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STATUS_OK) |->
         (rsp_ff.done_res && rsp_ff.read_value == '0))
      else $error("error status without completion or with read data");

   a_done_releases_lines: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.done_res) |->
         (!rsp_ff.busy_res && rsp_ff.sbus && !rsp_ff.sclk && !rsp_ff.sen))
      else $error("lines not idle on completion");

   a_sbus_low_when_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.sbus) |-> rsp_ff.busy_res)
      else $error("bus selected while idle");

endmodule
